// File: rtl/tlls_pkg.sv
// Package for the timestamp log line stripper: character codes, line and sequencer
// state types, the command passed from the front end to the back end, and the
// line classification functions. Depends on nothing else.
package tlls_pkg;

  // Character codes
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Stamp length and end of the transmit marker that follows it
  localparam logic [4:0] STAMP_LEN = 5'd26;
  localparam logic [4:0] TX_END    = 5'd30;
  localparam logic [4:0] POS_TX0   = 5'd26;
  localparam logic [4:0] POS_TX1   = 5'd27;
  localparam logic [4:0] POS_TX2   = 5'd28;
  localparam logic [4:0] POS_TX3   = 5'd29;

  // Command queue depth
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Segment levels of a command, in emission order
  localparam logic [2:0] SEG_PRE   = 3'd0;
  localparam logic [2:0] SEG_FLUSH = 3'd1;
  localparam logic [2:0] SEG_CR    = 3'd2;
  localparam logic [2:0] SEG_DATA  = 3'd3;
  localparam logic [2:0] SEG_POST  = 3'd4;

  typedef enum logic [1:0] {
    LM_UNDEC,
    LM_KEEP,
    LM_DROP
  } line_mode_t;

  typedef enum logic [2:0] {
    K_UNDEC,
    K_KEEP_RAW,
    K_KEEP_STAMP,
    K_DROP_HASH,
    K_DROP_TX
  } kind_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_PRE_CR,
    BS_PRE_LF,
    BS_FLUSH,
    BS_CR,
    BS_DATA,
    BS_POST_CR,
    BS_POST_LF,
    BS_MARK
  } back_state_t;

  // One command describes every result of one accepted input byte.
  typedef struct packed {
    logic       pre;        // CRLF for a deferred break
    logic       flush;      // replay held line bytes
    logic       from_stamp; // replay starts after the stamp
    logic [4:0] fend;       // replay stops before this position
    logic       cr;         // a held CR
    logic       byte_en;    // the input byte itself
    logic [7:0] data;
    logic       post;       // CRLF closing the line or the capture
    logic       last;       // final transaction of the capture
  } tlls_cmd_t;

  typedef struct packed {
    logic       we;
    logic [4:0] addr;
    logic [7:0] data;
  } tlls_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tlls_qstat_t;

  function automatic logic stamp_char_ok(input logic [4:0] pos, input logic [7:0] c);
    logic digit;
    logic ok;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    unique case (pos) inside
      5'd0:                      ok = (c == CH_LBRACK);
      [5'd1:5'd4], 5'd6, 5'd7, 5'd9, 5'd10, 5'd12, 5'd13, 5'd15, 5'd16,
      5'd18, 5'd19, [5'd21:5'd23]: ok = digit;
      5'd5, 5'd8:                ok = (c == CH_DASH);
      5'd11, 5'd25:              ok = (c == CH_SPACE);
      5'd14, 5'd17:              ok = (c == CH_COLON);
      5'd20:                     ok = (c == CH_DOT);
      5'd24:                     ok = (c == CH_RBRACK);
      default:                   ok = 1'b1;
    endcase
    return ok;
  endfunction

  function automatic logic tx_char_ok(input logic [4:0] pos, input logic [7:0] c);
    logic ok;
    unique case (pos)
      POS_TX0: ok = (c == CH_T);
      POS_TX1: ok = (c == CH_X);
      POS_TX2: ok = (c == CH_GT);
      POS_TX3: ok = (c == CH_SPACE);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

  // Decides the kind of a line from the prefix flags of its first n bytes.
  function automatic kind_t classify(input logic [4:0] n, input logic s, input logic t,
                                     input logic h0, input logic b1, input logic fin);
    kind_t k;
    if (s && (n >= STAMP_LEN)) begin
      if (!t) begin
        k = K_KEEP_STAMP;
      end else if (n >= TX_END) begin
        k = K_DROP_TX;
      end else if (fin) begin
        k = K_KEEP_STAMP;
      end else begin
        k = K_UNDEC;
      end
    end else if (s && !fin) begin
      k = K_UNDEC;
    end else if (n >= 5'd2) begin
      k = (h0 && b1) ? K_DROP_HASH : K_KEEP_RAW;
    end else if ((n == 5'd1) && h0 && !fin) begin
      k = K_UNDEC;
    end else begin
      k = K_KEEP_RAW;
    end
    return k;
  endfunction

endpackage

// File: rtl/tlls_front.sv
// Front end of the log line stripper: accepts capture bytes, tracks the line state,
// classifies each line and issues at most one command per byte. Depends on tlls_pkg.
module tlls_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                strip_en,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  tlls_pkg::tlls_qstat_t qstat,
  input  logic                flush_done,
  output logic                push,
  output tlls_pkg::tlls_cmd_t cmd,
  output tlls_pkg::tlls_wr_t  wr
);
  import tlls_pkg::*;

  line_mode_t mode_r, mode_nxt;
  logic [4:0] lp_r, lp_nxt;
  logic       pend_r, pend_nxt, pend_aft;
  logic       held_r, held_nxt;
  logic       s_r, s_nxt, t_r, t_nxt, h0_r, h0_nxt, b1_r, b1_nxt;
  logic [QAW:0] fcnt_r, fcnt_nxt;

  logic       accept, is_lf, is_cr, fin, use_upd, keep, decided, restart, post_step;
  logic       s_u, t_u, h0_u, b1_u;
  logic [4:0] n, fstart, fend;
  kind_t      kind;

  // A new line must not overwrite the lookahead while a replay of it is still queued.
  assign in_ready = !qstat.full && !((fcnt_r != '0) && (mode_r == LM_UNDEC) && strip_en);
  assign accept   = in_valid && in_ready;

  // Line analysis
  always_comb begin
    is_lf   = (in_byte == CH_LF);
    is_cr   = (in_byte == CH_CR);
    fin     = is_lf || in_last;
    s_u     = s_r && stamp_char_ok(lp_r, in_byte);
    t_u     = t_r && tx_char_ok(lp_r, in_byte);
    h0_u    = (lp_r == 5'd0) ? (in_byte == CH_HASH) : h0_r;
    b1_u    = (lp_r == 5'd1) ? (in_byte == CH_SPACE) : b1_r;
    // A closing LF, or a final CR, is not part of the classified line.
    use_upd = !(fin && (is_lf || is_cr));
    n       = use_upd ? (lp_r + 5'd1) : lp_r;
    kind    = use_upd ? classify(n, s_u, t_u, h0_u, b1_u, fin)
                      : classify(n, s_r, t_r, h0_r, b1_r, fin);
    keep    = (kind == K_KEEP_RAW) || (kind == K_KEEP_STAMP);
    decided = fin || (kind != K_UNDEC);
    fstart  = (kind == K_KEEP_STAMP) ? STAMP_LEN : 5'd0;
    fend    = (!fin && is_cr) ? (n - 5'd1) : n;
  end

  // Next line state
  always_comb begin
    mode_nxt = mode_r;
    lp_nxt   = lp_r;
    pend_aft = pend_r;
    held_nxt = held_r;
    s_nxt    = s_r;
    t_nxt    = t_r;
    h0_nxt   = h0_r;
    b1_nxt   = b1_r;
    restart  = 1'b0;
    if (!strip_en) begin
      mode_nxt = LM_UNDEC;
      pend_aft = 1'b0;
      held_nxt = 1'b0;
      restart  = 1'b1;
    end else begin
      unique case (mode_r)
        LM_UNDEC: begin
          if (!decided) begin
            lp_nxt = n;
            s_nxt  = s_u;
            t_nxt  = t_u;
            h0_nxt = h0_u;
            b1_nxt = b1_u;
          end else begin
            restart  = 1'b1;
            pend_aft = fin && keep && is_lf;
            held_nxt = !fin && keep && is_cr;
            mode_nxt = fin ? LM_UNDEC : (keep ? LM_KEEP : LM_DROP);
          end
        end
        LM_KEEP: begin
          if (is_lf) begin
            pend_aft = !held_r;
            held_nxt = 1'b0;
            mode_nxt = LM_UNDEC;
            restart  = 1'b1;
          end else begin
            held_nxt = is_cr;
          end
        end
        LM_DROP: begin
          if (is_lf) begin
            mode_nxt = LM_UNDEC;
            restart  = 1'b1;
          end
        end
        default: begin
          mode_nxt = LM_UNDEC;
          restart  = 1'b1;
        end
      endcase
    end
    pend_nxt = pend_aft;
    if (restart || in_last) begin
      lp_nxt = 5'd0;
      s_nxt  = 1'b1;
      t_nxt  = 1'b1;
      h0_nxt = 1'b0;
      b1_nxt = 1'b0;
    end
    if (in_last) begin
      mode_nxt = LM_UNDEC;
      pend_nxt = 1'b0;
      held_nxt = 1'b0;
    end
  end

  // Command for the back end
  always_comb begin
    cmd            = '0;
    cmd.data       = in_byte;
    cmd.fend       = fend;
    cmd.from_stamp = (kind == K_KEEP_STAMP);
    cmd.last       = in_last;
    post_step      = 1'b0;
    if (!strip_en) begin
      cmd.byte_en = 1'b1;
    end else begin
      unique case (mode_r)
        LM_UNDEC: begin
          if (decided && (kind != K_DROP_TX)) begin
            cmd.pre   = pend_r;
            cmd.flush = keep && (fend > fstart);
          end
        end
        LM_KEEP: begin
          if (is_lf) begin
            post_step = held_r;
          end else begin
            cmd.cr      = held_r;
            cmd.byte_en = !is_cr;
          end
        end
        default: begin
          post_step = 1'b0;
        end
      endcase
    end
    cmd.post = post_step || (in_last && pend_aft);
  end

  assign push = accept && (cmd.pre || cmd.flush || cmd.cr || cmd.byte_en || cmd.post ||
                           cmd.last);

  always_comb begin
    wr.we   = accept && strip_en && (mode_r == LM_UNDEC) && !is_lf;
    wr.addr = lp_r;
    wr.data = in_byte;
  end

  always_comb begin
    fcnt_nxt = fcnt_r;
    if (push && cmd.flush) begin
      fcnt_nxt = fcnt_nxt + 1'b1;
    end
    if (flush_done) begin
      fcnt_nxt = fcnt_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= LM_UNDEC;
      lp_r   <= 5'd0;
      pend_r <= 1'b0;
      held_r <= 1'b0;
      s_r    <= 1'b1;
      t_r    <= 1'b1;
      h0_r   <= 1'b0;
      b1_r   <= 1'b0;
      fcnt_r <= '0;
    end else begin
      fcnt_r <= fcnt_nxt;
      if (accept) begin
        mode_r <= mode_nxt;
        lp_r   <= lp_nxt;
        pend_r <= pend_nxt;
        held_r <= held_nxt;
        s_r    <= s_nxt;
        t_r    <= t_nxt;
        h0_r   <= h0_nxt;
        b1_r   <= b1_nxt;
      end
    end
  end

endmodule

// File: rtl/tlls_fifo.sv
// Short command queue between the front and back ends of the log line stripper.
// Depends on tlls_pkg for the command type and the queue depth.
module tlls_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tlls_pkg::tlls_cmd_t   din,
  input  logic                  pop,
  output tlls_pkg::tlls_cmd_t   dout,
  output tlls_pkg::tlls_qstat_t stat
);
  import tlls_pkg::*;

  tlls_cmd_t      mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
    end
  end

  assign dout       = mem_r[rp_r];
  assign stat.full  = (cnt_r == (QAW + 1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// File: rtl/tlls_back.sv
// Back end of the log line stripper: holds the lookahead memory and sequences each
// command into output transactions through a registered output stage. Depends on tlls_pkg.
module tlls_back #(
  parameter int LOOKAHEAD_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tlls_pkg::tlls_wr_t    wr,
  input  tlls_pkg::tlls_cmd_t   head,
  input  tlls_pkg::tlls_qstat_t qstat,
  output logic                  pop,
  output logic                  flush_done,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_byte_valid,
  output logic                  out_run_last,
  output logic                  out_stream_end
);
  import tlls_pkg::*;

  localparam int AW = $clog2(LOOKAHEAD_DEPTH);

  logic [7:0]  mem [LOOKAHEAD_DEPTH];
  logic [7:0]  rdata_r;

  back_state_t state_r, state_nxt, follow, step, first_st;
  tlls_cmd_t   cmd_r, cmd_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic        out_valid_r;
  logic [7:0]  out_byte_r, o_byte;
  logic        out_bv_r, out_rl_r, out_se_r, o_bv;
  logic        slot_free, emit, seg_end, item_last, done;

  // First enabled segment at or after the given level; BS_IDLE when none remains.
  function automatic back_state_t next_seg(input tlls_cmd_t c, input logic [2:0] lvl);
    back_state_t s;
    s = BS_IDLE;
    if ((lvl <= SEG_POST) && c.post) s = BS_POST_CR;
    if ((lvl <= SEG_DATA) && c.byte_en) s = BS_DATA;
    if ((lvl <= SEG_CR) && c.cr) s = BS_CR;
    if ((lvl <= SEG_FLUSH) && c.flush) s = BS_FLUSH;
    if ((lvl <= SEG_PRE) && c.pre) s = BS_PRE_CR;
    return s;
  endfunction

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = (state_r != BS_IDLE) && slot_free;

  // Sequencer next state
  always_comb begin
    seg_end = 1'b0;
    follow  = BS_IDLE;
    step    = state_r;
    unique case (state_r)
      BS_IDLE:    step = BS_IDLE;
      BS_PRE_CR:  step = BS_PRE_LF;
      BS_PRE_LF: begin
        seg_end = 1'b1;
        follow  = next_seg(cmd_r, SEG_FLUSH);
      end
      BS_FLUSH: begin
        seg_end = ((idx_r + 5'd1) == cmd_r.fend);
        follow  = next_seg(cmd_r, SEG_CR);
        step    = BS_FLUSH;
      end
      BS_CR: begin
        seg_end = 1'b1;
        follow  = next_seg(cmd_r, SEG_DATA);
      end
      BS_DATA: begin
        seg_end = 1'b1;
        follow  = next_seg(cmd_r, SEG_POST);
      end
      BS_POST_CR: step = BS_POST_LF;
      BS_POST_LF: seg_end = 1'b1;
      BS_MARK:    seg_end = 1'b1;
      default:    step = BS_IDLE;
    endcase
    item_last = seg_end && (follow == BS_IDLE);
    done      = emit && item_last;
    pop       = !qstat.empty && ((state_r == BS_IDLE) || done);
    first_st  = next_seg(head, SEG_PRE);
    if (first_st == BS_IDLE) begin
      first_st = BS_MARK;
    end
    if (pop) begin
      state_nxt = first_st;
    end else if (done) begin
      state_nxt = BS_IDLE;
    end else if (emit) begin
      state_nxt = seg_end ? follow : step;
    end else begin
      state_nxt = state_r;
    end
    cmd_nxt = pop ? head : cmd_r;
    if (pop) begin
      idx_nxt = head.from_stamp ? STAMP_LEN : 5'd0;
    end else if (emit && (state_r == BS_FLUSH)) begin
      idx_nxt = idx_r + 5'd1;
    end else begin
      idx_nxt = idx_r;
    end
    flush_done = emit && (state_r == BS_FLUSH) && seg_end;
  end

  // Output selection
  always_comb begin
    o_bv = 1'b1;
    unique case (state_r)
      BS_PRE_CR, BS_CR, BS_POST_CR: o_byte = CH_CR;
      BS_PRE_LF, BS_POST_LF:        o_byte = CH_LF;
      BS_FLUSH:                     o_byte = rdata_r;
      BS_DATA:                      o_byte = cmd_r.data;
      default: begin
        o_byte = CH_NUL;
        o_bv   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[AW'(wr.addr)] <= wr.data;
    end
    rdata_r <= mem[AW'(idx_nxt)];
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    if (emit) begin
      out_byte_r <= o_byte;
      out_bv_r   <= o_bv;
      out_rl_r   <= item_last;
      out_se_r   <= item_last && cmd_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_run_last   = out_rl_r;
  assign out_stream_end = out_se_r;

endmodule

// File: rtl/timestamp_log_line_stripper.sv
// A byte's first result passes through the command queue, the sequencer state and the
// registered output stage, whether the back end is idle or just finishing earlier work;
// results still ahead of it delay it further. Throughput: one result per cycle from the
// back-end sequencer while the receiver is ready; the front end takes one byte per cycle
// while the queue is not full, but holds off the first byte of a new line while a replay
// of up to 26 lookahead bytes is still queued. Reset is synchronous: line state, queue and
// output are cleared and strip_enable returns to 1; the lookahead memory is not cleared.
module timestamp_log_line_stripper #(
  parameter int LOOKAHEAD_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_run_last,
  output logic       out_stream_end,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import tlls_pkg::*;

  // The single configuration register. The user must write it only while the block is
  // idle, so that the front end may read it directly; the block itself does not enforce it.
  logic strip_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_en_r <= 1'b1;
    end else if (cfg_we) begin
      strip_en_r <= cfg_wdata;
    end
  end

  tlls_cmd_t   q_in, q_head;
  tlls_qstat_t q_stat;
  tlls_wr_t    buf_wr;
  logic        q_push, q_pop, flush_done;

  // The front end classifies each line from running prefix flags and turns every
  // accepted transaction into at most one command. Bytes of a line that is still undecided
  // are parked in the lookahead memory held by the back end.
  tlls_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .strip_en   (strip_en_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .qstat      (q_stat),
    .flush_done (flush_done),
    .push       (q_push),
    .cmd        (q_in),
    .wr         (buf_wr)
  );

  // The queue lets the front end run ahead while the back end is still expanding a
  // command into several output transactions.
  tlls_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_head),
    .stat  (q_stat)
  );

  // The back end emits, in order, a deferred line break, the replayed lookahead
  // bytes, a held CR, the byte itself and a closing line break, or a bare end
  // marker when the final transaction of a capture produces nothing else.
  tlls_back #(
    .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr             (buf_wr),
    .head           (q_head),
    .qstat          (q_stat),
    .pop            (q_pop),
    .flush_done     (flush_done),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_last   (out_run_last),
    .out_stream_end (out_stream_end)
  );

`ifndef SYNTH
  // The front end must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("command pushed into a full queue");

  // A result without data is only ever the end marker of a capture.
  a_marker_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_byte_valid) |-> (out_run_last && out_stream_end))
    else $error("data-less result that is not an end marker");

  // The end of a capture always closes the results of its transaction.
  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stream_end) |-> out_run_last)
    else $error("stream end without run end");

  // A queue pop is only taken when there is something to take.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from an empty queue");
`endif

endmodule

// File: tb/sv/tlls_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the timestamp log line stripper testbench: a predictor of the cleaned
// byte stream and the queue of results that the block still owes.
// Depends on tlls_pkg for character codes, line modes and line kinds.
package tlls_tb_pkg;
  import tlls_pkg::*;

  localparam logic [0:25][7:0] STAMP_SHAPE = "[dddd-dd-dd dd:dd:dd.ddd] ";
  localparam logic [0:3][7:0]  TX_MARKER   = "TX> ";
  localparam int STAMP_BYTES  = 26;
  localparam int TX_LIMIT     = 30;
  localparam int HOLD_DEPTH   = 32;
  localparam int MAX_PER_BYTE = 32;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       run_last;
    logic       stream_end;
  } cleaned_out_t;

  class stripped_stream_scoreboard;
    logic         strip_on;
    int           held_count;
    line_mode_t   mode;
    logic [7:0]   held_line [HOLD_DEPTH];
    logic         break_owed;
    logic         cr_held;
    cleaned_out_t step_out[$];
    cleaned_out_t owed[$];
    int unsigned  mismatches;

    function new();
      strip_on   = 1'b1;
      mismatches = 0;
      restart_line_state();
    endfunction

    function void restart_line_state();
      held_count = 0;
      mode       = LM_UNDEC;
      break_owed = 1'b0;
      cr_held    = 1'b0;
    endfunction

    function void set_strip(logic on);
      strip_on = on;
    endfunction

    function int unsigned outstanding();
      return owed.size();
    endfunction

    function void emit(logic [7:0] b);
      cleaned_out_t r;
      if (step_out.size() >= MAX_PER_BYTE) return;
      r.data       = b;
      r.byte_valid = 1'b1;
      r.run_last   = 1'b0;
      r.stream_end = 1'b0;
      step_out.push_back(r);
    endfunction

    function void emit_crlf();
      emit(CH_CR);
      emit(CH_LF);
    endfunction

    function logic stamp_fits(int pos, logic [7:0] c);
      if (STAMP_SHAPE[pos] == "d") return (c >= CH_ZERO) && (c <= CH_NINE);
      return c == STAMP_SHAPE[pos];
    endfunction

    // Kind of the line from its first n held bytes; fin means the line is complete.
    function kind_t judge_line(int n, logic fin);
      int   span;
      int   stop;
      int   i;
      logic miss;
      span = (n < STAMP_BYTES) ? n : STAMP_BYTES;
      miss = 1'b0;
      for (i = 0; i < span && !miss; i++) begin
        if (!stamp_fits(i, held_line[i])) miss = 1'b1;
      end
      if (!miss && n >= STAMP_BYTES) begin
        stop = (n < TX_LIMIT) ? n : TX_LIMIT;
        for (i = STAMP_BYTES; i < stop; i++) begin
          if (held_line[i] != TX_MARKER[i - STAMP_BYTES]) return K_KEEP_STAMP;
        end
        if (n >= TX_LIMIT) return K_DROP_TX;
        return fin ? K_KEEP_STAMP : K_UNDEC;
      end
      if (!miss && !fin) return K_UNDEC;
      if (n >= 2) begin
        return (held_line[0] == CH_HASH && held_line[1] == CH_SPACE) ? K_DROP_HASH : K_KEEP_RAW;
      end
      if (n == 1 && held_line[0] == CH_HASH && !fin) return K_UNDEC;
      return K_KEEP_RAW;
    endfunction

    function void settle_line(kind_t kind, int n, logic fin);
      int first;
      int i;
      first = (kind == K_KEEP_STAMP) ? STAMP_BYTES : 0;
      if (kind == K_DROP_TX) begin
        break_owed = 1'b0;
        mode       = LM_DROP;
        return;
      end
      if (break_owed) begin
        emit_crlf();
        break_owed = 1'b0;
      end
      if (kind == K_DROP_HASH) begin
        mode = LM_DROP;
        return;
      end
      mode = LM_KEEP;
      for (i = first; i < n && i < HOLD_DEPTH; i++) begin
        if (!fin && i + 1 == n && held_line[i] == CH_CR) cr_held = 1'b1;
        else emit(held_line[i]);
      end
    endfunction

    function void strip_step(logic [7:0] c, logic last);
      int    n;
      logic  cr;
      kind_t kind;
      if (mode == LM_UNDEC) begin
        if (c == CH_LF || last) begin
          n = held_count;
          if (c != CH_LF && n < HOLD_DEPTH) begin
            held_line[n] = c;
            n++;
          end
          cr = 1'b0;
          if (n > 0) cr = (held_line[n - 1] == CH_CR);
          if (cr) n--;
          kind = judge_line(n, 1'b1);
          settle_line(kind, n, 1'b1);
          if (c == CH_LF && (kind == K_KEEP_RAW || kind == K_KEEP_STAMP)) begin
            if (cr) emit_crlf();
            else break_owed = 1'b1;
          end
          held_count = 0;
          mode       = LM_UNDEC;
        end else begin
          if (held_count < HOLD_DEPTH) begin
            held_line[held_count] = c;
            held_count++;
          end
          kind = judge_line(held_count, 1'b0);
          if (kind != K_UNDEC) begin
            settle_line(kind, held_count, 1'b0);
            held_count = 0;
          end
        end
      end else if (mode == LM_KEEP) begin
        if (c == CH_LF) begin
          if (cr_held) begin
            emit_crlf();
            cr_held = 1'b0;
          end else begin
            break_owed = 1'b1;
          end
          mode = LM_UNDEC;
        end else if (c == CH_CR) begin
          if (cr_held) emit(CH_CR);
          cr_held = 1'b1;
        end else begin
          if (cr_held) begin
            emit(CH_CR);
            cr_held = 1'b0;
          end
          emit(c);
        end
      end else if (c == CH_LF) begin
        mode = LM_UNDEC;
      end
      if (last) begin
        cr_held = 1'b0;
        if (break_owed) emit_crlf();
        restart_line_state();
      end
    endfunction

    // Called for every accepted input transaction.
    function void note_byte(logic [7:0] c, logic last);
      cleaned_out_t marker;
      int           tail;
      step_out.delete();
      if (strip_on) begin
        strip_step(c, last);
      end else begin
        restart_line_state();
        emit(c);
      end
      if (last && step_out.size() == 0) begin
        marker = '0;
        step_out.push_back(marker);
      end
      if (step_out.size() > 0) begin
        tail = step_out.size() - 1;
        step_out[tail].run_last = 1'b1;
        if (last) step_out[tail].stream_end = 1'b1;
      end
      foreach (step_out[i]) owed.push_back(step_out[i]);
    endfunction

    // Called for every accepted result transaction.
    function void check_output(logic [7:0] data, logic bv, logic rl, logic se);
      cleaned_out_t want;
      if (owed.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected: expected none, got byte %02h valid %0b",
                 $time, data, bv, " run_last %0b stream_end %0b", rl, se);
        return;
      end
      want = owed.pop_front();
      if (data !== want.data || bv !== want.byte_valid || rl !== want.run_last ||
          se !== want.stream_end) begin
        mismatches++;
        $display("%0t: expected byte %02h valid %0b run_last %0b stream_end %0b", $time,
                 want.data, want.byte_valid, want.run_last, want.stream_end);
        $display("%0t:      got byte %02h valid %0b run_last %0b stream_end %0b", $time,
                 data, bv, rl, se);
      end
    endfunction
  endclass

endpackage

// File: tb/sv/timestamp_log_line_stripper_tb.sv
`timescale 1ns / 100ps
// Top level of the testbench for timestamp_log_line_stripper: clock, reset, stimulus,
// a randomly stalling receiver and the result monitor, all in plain tasks and processes.
// Depends on tlls_pkg, on tlls_tb_pkg (scoreboard) and on the RTL of the block.
module timestamp_log_line_stripper_tb;
  import tlls_pkg::*;
  import tlls_tb_pkg::*;

  // Cycles allowed after the last expected result before the block is treated as idle.
  // Bytes of a dropped line cause no result, so the block may still be busy with one.
  localparam int DRAIN_TAIL       = 12;
  localparam int LONG_HOLD_CYCLES = 200;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } capture_item_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_run_last;
  logic       out_stream_end;
  logic       cfg_we;
  logic       cfg_wdata;

  int unsigned send_idle_pct     = 0;
  int unsigned recv_idle_pct     = 0;
  int unsigned long_hold_request = 0;

  capture_item_t             capture_q[$];
  stripped_stream_scoreboard sb;

  timestamp_log_line_stripper dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_last   (out_run_last),
    .out_stream_end (out_stream_end),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("timestamp_log_line_stripper verification failed");
    $finish;
  end

  // Receiver: drops ready at random, and on request holds it low for a long stretch so
  // that the block fills up and has to stall its input side.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_request != 0) begin
        hold_left         = long_hold_request;
        long_hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Every result transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_output(out_byte, out_byte_valid, out_run_last, out_stream_end);
    end
  end

  task automatic push_byte(logic [7:0] b, logic last);
    capture_item_t it;
    it.b    = b;
    it.last = last;
    capture_q.push_back(it);
  endtask

  task automatic push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  // Closes the capture on the most recently queued byte.
  task automatic end_capture_here();
    capture_item_t it;
    if (capture_q.size() == 0) push_byte(CH_NUL, 1'b0);
    it      = capture_q.pop_back();
    it.last = 1'b1;
    capture_q.push_back(it);
  endtask

  // The first cut bytes of a well-formed stamp, with random digits.
  task automatic push_stamp(int cut);
    int i;
    for (i = 0; i < cut; i++) begin
      if (STAMP_SHAPE[i] == "d") push_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
      else push_byte(STAMP_SHAPE[i], 1'b0);
    end
  endtask

  // Line content: mostly printable text, with the odd embedded CR or arbitrary byte.
  function automatic logic [7:0] body_char();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return CH_CR;
    if (pick == 1) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(32, 126));
  endfunction

  // One line of a capture. Most lines are well formed (stamped text, transmit echoes,
  // comments); the rest are near misses, truncated or broken stamps and raw noise.
  task automatic push_random_line();
    int unsigned sel;
    int unsigned cut;
    int unsigned len;
    int unsigned i;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: begin
        push_stamp(STAMP_BYTES);
      end
      3, 4: begin
        push_stamp(STAMP_BYTES);
        push_text("TX> ");
      end
      5: begin
        // Stamp followed by a transmit marker that goes wrong part way through.
        push_stamp(STAMP_BYTES);
        cut = $urandom_range(1, 4);
        for (i = 0; i + 1 < cut; i++) push_byte(TX_MARKER[i], 1'b0);
        push_byte(8'($urandom_range(32, 126)), 1'b0);
      end
      6: begin
        push_text("# ");
      end
      7: begin
        if ($urandom_range(0, 1) == 1) push_byte(CH_HASH, 1'b0);
      end
      8: begin
        push_stamp($urandom_range(0, STAMP_BYTES - 1));
        push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      default: begin
        len = $urandom_range(1, 8);
        for (i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase
    len = $urandom_range(0, 6);
    for (i = 0; i < len; i++) push_byte(body_char(), 1'b0);
    case ($urandom_range(0, 7))
      0, 1, 2: push_text("\r\n");
      3, 4:    push_byte(CH_LF, 1'b0);
      5:       push_text("\r\r\n");
      6:       ; // no break: the next line runs on from this one
      default: push_byte(CH_CR, 1'b1); // capture ends on a lone CR
    endcase
    if ($urandom_range(0, 7) == 0) end_capture_here();
  endtask

  task automatic build_random_part(int target, logic close);
    while (capture_q.size() < target) push_random_line();
    if (close) end_capture_here();
  endtask

  // Offers every queued byte in turn. Valid rises at a falling edge and stays up with
  // the payload unchanged until the transaction is taken at a rising edge.
  task automatic send_capture();
    capture_item_t it;
    while (capture_q.size() != 0) begin
      it = capture_q.pop_front();
      @(negedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      in_byte  <= it.b;
      in_last  <= it.last;
      do @(posedge clk); while (!in_ready);
      sb.note_byte(it.b, it.last);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Waits for every expected result, then gives silent bytes time to pass through.
  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_strip_enable(logic on);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= on;
    @(posedge clk);
    sb.set_strip(on);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    in_last   = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // First phase: stripping on, sender idles a little, receiver a lot.
    send_idle_pct = 31;
    recv_idle_pct = 88;
    write_strip_enable(1'b1);
    push_text("# x\n");           // comment line vanishes with its break
    push_text("a\r\n");           // CRLF closes the line at once
    push_text("b\n");             // bare LF is held back
    push_byte(8'h00, 1'b0);       // held break comes out before the next kept line
    push_byte(8'hFF, 1'b0);
    push_byte(CH_CR, 1'b1);       // a CR as the final byte is dropped: end marker only
    push_byte(CH_HASH, 1'b1);     // a lone '#' at the end of a capture is kept
    push_text("z\n# ");           // held break still precedes a comment line
    push_byte("q", 1'b1);         // capture ends inside the comment: end marker only
    push_text("[1\n");            // a stamp that stops short is ordinary text
    push_byte(CH_LF, 1'b1);       // empty line, then both held breaks at the end
    send_capture();
    // Hold the receiver off while the sender keeps offering, so the block backs up.
    @(posedge clk);
    long_hold_request = LONG_HOLD_CYCLES;
    // Each byte of a plain line but the CR gives a command, enough to fill the queue for certain.
    push_text("filled up\r\n");
    build_random_part(25, 1'b1);
    send_capture();
    wait_drained();

    // Second phase: pass-through mode, sender idles a lot, receiver a little.
    send_idle_pct = 88;
    recv_idle_pct = 31;
    write_strip_enable(1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(CH_LF, 1'b0);
    push_byte(8'h00, 1'b1);
    build_random_part(12, 1'b1);
    send_capture();
    wait_drained();

    // Third phase: stripping again at full rate, with the sender pausing mid-capture
    // until the block has delivered everything it owes.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_strip_enable(1'b1);
    build_random_part(12, 1'b0);
    send_capture();
    wait_drained();
    build_random_part(12, 1'b1);
    send_capture();
    wait_drained();

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("timestamp_log_line_stripper verification clean");
    end else begin
      $display("timestamp_log_line_stripper verification failed");
    end
    $finish;
  end

endmodule

// File: timestamp_log_line_stripper.f
rtl/tlls_pkg.sv
rtl/tlls_front.sv
rtl/tlls_fifo.sv
rtl/tlls_back.sv
rtl/timestamp_log_line_stripper.sv
tb/sv/tlls_tb_pkg.sv
tb/sv/timestamp_log_line_stripper_tb.sv
